@@ hw/rtl/ipd_pkg.sv @@
// Shared types, constants and duration-match helpers for the IR frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package ipd_pkg;

  // Configuration port geometry
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // Register reset values
  localparam logic [15:0] RstLeaderMark  = 16'd9000;
  localparam logic [15:0] RstLeaderSpace = 16'd4500;
  localparam logic [15:0] RstBitMark     = 16'd560;
  localparam logic [15:0] RstZeroSpace   = 16'd560;
  localparam logic [15:0] RstOneSpace    = 16'd1690;
  localparam logic [15:0] RstGapSpace    = 16'd8000;
  localparam logic [15:0] RstTolerance   = 16'd200;
  localparam logic        RstChecksumEn  = 1'b1;

  // Register index map (byte address is 4 * index)
  typedef enum logic [2:0] {
    REG_LEADER_MARK  = 3'd0,
    REG_LEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ZERO_SPACE   = 3'd3,
    REG_ONE_SPACE    = 3'd4,
    REG_GAP_SPACE    = 3'd5,
    REG_TOLERANCE    = 3'd6,
    REG_CHECKSUM_EN  = 3'd7
  } ipd_reg_e;

  // Frame decode phase
  typedef enum logic [2:0] {
    PH_WAIT_LEADER = 3'd0,
    PH_DATA        = 3'd1,
    PH_STOP        = 3'd2,
    PH_FAIL        = 3'd3,
    PH_DONE        = 3'd4
  } ipd_phase_e;

  // Timing configuration seen by the decoder
  typedef struct packed {
    logic [15:0] leader_mark_us;
    logic [15:0] leader_space_us;
    logic [15:0] bit_mark_us;
    logic [15:0] zero_space_us;
    logic [15:0] one_space_us;
    logic [15:0] gap_space_us;
    logic [15:0] tolerance_us;
    logic        checksum_enable;
  } ipd_cfg_t;

  // Readout request from decoder to emitter
  typedef struct packed {
    logic start;      // frame ended valid, start reading the store
    logic drop_last;  // checksum byte is not emitted
  } ipd_emit_req_t;

  // Lower edge of the window, clamped at zero
  function automatic logic [16:0] dur_lower(logic [15:0] nom, logic [15:0] tol);
    logic [16:0] lo;
    lo = (nom > tol) ? {1'b0, nom - tol} : 17'd0;
    return lo;
  endfunction

  // Upper edge of the window, one bit wider so it cannot wrap
  function automatic logic [16:0] dur_upper(logic [15:0] nom, logic [15:0] tol);
    logic [16:0] hi;
    hi = {1'b0, nom} + {1'b0, tol};
    return hi;
  endfunction

  // Duration inside nominal +/- tolerance
  function automatic logic dur_match(logic [15:0] nom, logic [15:0] tol, logic [15:0] d);
    logic ok;
    ok = ({1'b0, d} >= dur_lower(nom, tol)) && ({1'b0, d} <= dur_upper(nom, tol));
    return ok;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ipd_in_if.sv @@
// Request channel carrying one frame start or one mark/space pair.
`timescale 1ns / 1ps
`default_nettype none
interface ipd_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] mark_us;
  logic [15:0] space_us;

  modport source (output valid, output req_type, output mark_us, output space_us,
                  input ready);
  modport sink   (input valid, input req_type, input mark_us, input space_us,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ipd_out_if.sv @@
// Result channel carrying one decoded payload byte with its last flag.
`timescale 1ns / 1ps
`default_nettype none
interface ipd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ipd_cfg_regs.sv @@
// APB-style register file holding the decoder timing configuration.
`timescale 1ns / 1ps
`default_nettype none
module ipd_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ipd_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [ipd_pkg::ApbDataW-1:0]  pwdata,
  output      logic [ipd_pkg::ApbDataW-1:0]  prdata,
  output      logic                          pready,
  output      ipd_pkg::ipd_cfg_t             cfg_o
);
  import ipd_pkg::*;

  ipd_cfg_t cfg_q, cfg_d;
  ipd_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = ipd_reg_e'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite;
  assign cfg_o   = cfg_q;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_LEADER_MARK:  cfg_d.leader_mark_us  = pwdata[15:0];
        REG_LEADER_SPACE: cfg_d.leader_space_us = pwdata[15:0];
        REG_BIT_MARK:     cfg_d.bit_mark_us     = pwdata[15:0];
        REG_ZERO_SPACE:   cfg_d.zero_space_us   = pwdata[15:0];
        REG_ONE_SPACE:    cfg_d.one_space_us    = pwdata[15:0];
        REG_GAP_SPACE:    cfg_d.gap_space_us    = pwdata[15:0];
        REG_TOLERANCE:    cfg_d.tolerance_us    = pwdata[15:0];
        REG_CHECKSUM_EN:  cfg_d.checksum_enable = pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_LEADER_MARK:  prdata = {16'd0, cfg_q.leader_mark_us};
      REG_LEADER_SPACE: prdata = {16'd0, cfg_q.leader_space_us};
      REG_BIT_MARK:     prdata = {16'd0, cfg_q.bit_mark_us};
      REG_ZERO_SPACE:   prdata = {16'd0, cfg_q.zero_space_us};
      REG_ONE_SPACE:    prdata = {16'd0, cfg_q.one_space_us};
      REG_GAP_SPACE:    prdata = {16'd0, cfg_q.gap_space_us};
      REG_TOLERANCE:    prdata = {16'd0, cfg_q.tolerance_us};
      REG_CHECKSUM_EN:  prdata = {31'd0, cfg_q.checksum_enable};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_mark_us  <= RstLeaderMark;
      cfg_q.leader_space_us <= RstLeaderSpace;
      cfg_q.bit_mark_us     <= RstBitMark;
      cfg_q.zero_space_us   <= RstZeroSpace;
      cfg_q.one_space_us    <= RstOneSpace;
      cfg_q.gap_space_us    <= RstGapSpace;
      cfg_q.tolerance_us    <= RstTolerance;
      cfg_q.checksum_enable <= RstChecksumEn;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ipd_frame_store.sv @@
// Frame byte memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ipd_frame_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output      logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  assign rd_data_o = rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ipd_decoder.sv @@
// Symbol decoder: leader, bit and stop checks, byte assembly and checksum.
`timescale 1ns / 1ps
`default_nettype none
module ipd_decoder #(
  parameter int unsigned FRAME_BYTES       = 16,
  parameter int unsigned FIRST_BLOCK_BYTES = 6,
  parameter int unsigned CUSTOMER_BYTES    = 2,
  parameter int unsigned AW                = 4,
  parameter int unsigned CW                = 5
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ipd_pkg::ipd_cfg_t      cfg_i,
  input  wire logic                   accept_i,
  input  wire logic                   req_type_i,
  input  wire logic [15:0]            mark_us_i,
  input  wire logic [15:0]            space_us_i,
  output      logic                   wr_en_o,
  output      logic [AW-1:0]          wr_addr_o,
  output      logic [7:0]             wr_data_o,
  output      ipd_pkg::ipd_emit_req_t emit_o
);
  import ipd_pkg::*;

  ipd_phase_e    phase_q, phase_d;
  logic [2:0]    bit_pos_q, bit_pos_d;
  logic [7:0]    asm_q, asm_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    xor_q, xor_d;
  logic [7:0]    final_q, final_d;

  logic          leader_ok, mark_ok, zero_ok, one_ok;
  logic          gap_min_ok, gap_max_ok;
  logic [7:0]    new_byte;
  logic [CW-1:0] count_inc;

  // Window checks, all in parallel
  assign leader_ok  = dur_match(cfg_i.leader_mark_us, cfg_i.tolerance_us, mark_us_i) &&
                      dur_match(cfg_i.leader_space_us, cfg_i.tolerance_us, space_us_i);
  assign mark_ok    = dur_match(cfg_i.bit_mark_us, cfg_i.tolerance_us, mark_us_i);
  assign zero_ok    = dur_match(cfg_i.zero_space_us, cfg_i.tolerance_us, space_us_i);
  assign one_ok     = dur_match(cfg_i.one_space_us, cfg_i.tolerance_us, space_us_i);
  assign gap_min_ok = {1'b0, space_us_i} >= dur_lower(cfg_i.gap_space_us, cfg_i.tolerance_us);
  assign gap_max_ok = {1'b0, space_us_i} <= dur_upper(cfg_i.gap_space_us, cfg_i.tolerance_us);

  // Zero wins when both windows overlap; a one sets the current bit, LSB first
  assign new_byte  = asm_q | ({7'd0, ~zero_ok} << bit_pos_q);
  assign count_inc = count_q + 1'b1;

  assign wr_addr_o = count_q[AW-1:0];
  assign wr_data_o = new_byte;

  // Next state and store write
  always_comb begin
    phase_d   = phase_q;
    bit_pos_d = bit_pos_q;
    asm_d     = asm_q;
    count_d   = count_q;
    xor_d     = xor_q;
    final_d   = final_q;
    wr_en_o   = 1'b0;
    emit_o    = '0;
    if (accept_i) begin
      if (req_type_i) begin
        phase_d   = PH_WAIT_LEADER;
        bit_pos_d = '0;
        asm_d     = '0;
        count_d   = '0;
        xor_d     = '0;
      end else begin
        unique case (phase_q)
          PH_WAIT_LEADER: begin
            phase_d = leader_ok ? PH_DATA : PH_FAIL;
          end
          PH_DATA: begin
            if (!mark_ok || !(zero_ok || one_ok)) begin
              phase_d = PH_FAIL;
            end else begin
              bit_pos_d = bit_pos_q + 3'd1;
              if (bit_pos_q == 3'd7) begin
                // byte complete
                if (count_q >= CW'(CUSTOMER_BYTES) && count_q < CW'(FRAME_BYTES - 1)) begin
                  xor_d = xor_q ^ new_byte;
                end
                if (count_q < CW'(FRAME_BYTES)) begin
                  wr_en_o = 1'b1;
                end
                if (count_q == CW'(FRAME_BYTES - 1)) begin
                  final_d = new_byte;
                end
                count_d = count_inc;
                asm_d   = '0;
                if (count_inc == CW'(FIRST_BLOCK_BYTES) || count_inc >= CW'(FRAME_BYTES)) begin
                  phase_d = PH_STOP;
                end
              end else begin
                asm_d = new_byte;
              end
            end
          end
          PH_STOP: begin
            phase_d = PH_FAIL;
            if (mark_ok && gap_min_ok) begin
              if (gap_max_ok) begin
                // inter-block gap
                if (count_q == CW'(FIRST_BLOCK_BYTES)) begin
                  phase_d = PH_DATA;
                end
              end else if (count_q == CW'(FRAME_BYTES) &&
                           (!cfg_i.checksum_enable || xor_q == final_q)) begin
                // final stop, frame valid
                phase_d          = PH_DONE;
                emit_o.start     = 1'b1;
                emit_o.drop_last = cfg_i.checksum_enable;
              end
            end
          end
          default: ;  // failed or done: ignore pairs
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT_LEADER;
      bit_pos_q <= '0;
      asm_q     <= '0;
      count_q   <= '0;
      xor_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      bit_pos_q <= bit_pos_d;
      asm_q     <= asm_d;
      count_q   <= count_d;
      xor_q     <= xor_d;
    end
  end

  // Copy of the last stored byte for the checksum compare
  always_ff @(posedge clk_i) begin
    final_q <= final_d;
  end

endmodule
`default_nettype wire

@@ hw/rtl/ipd_emitter.sv @@
// Readout sequencer: streams stored bytes through the output register.
`timescale 1ns / 1ps
`default_nettype none
module ipd_emitter #(
  parameter int unsigned FRAME_BYTES = 16,
  parameter int unsigned AW          = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ipd_pkg::ipd_emit_req_t emit_i,
  output      logic                   busy_o,
  output      logic                   rd_en_o,
  output      logic [AW-1:0]          rd_addr_o,
  input  wire logic [7:0]             rd_data_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      logic [7:0]             out_byte_o,
  output      logic                   out_last_o
);
  import ipd_pkg::*;

  logic          active_q, active_d;    // reads left to issue
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [AW-1:0] last_idx_q, last_idx_d;
  logic          pend_q, pend_d;        // read data waiting in the memory register
  logic          pend_last_q, pend_last_d;
  logic          ovalid_q, ovalid_d;
  logic [7:0]    obyte_q, obyte_d;
  logic          olast_q, olast_d;

  logic          out_free, consume, issue;

  assign out_free = ~ovalid_q | out_ready_i;
  assign consume  = pend_q & out_free;
  assign issue    = active_q & (~pend_q | consume);

  assign busy_o      = active_q | pend_q;
  assign rd_en_o     = issue;
  assign rd_addr_o   = rd_idx_q;
  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;

  // Read issue, skid and output register
  always_comb begin
    active_d    = active_q;
    rd_idx_d    = rd_idx_q;
    last_idx_d  = last_idx_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    ovalid_d    = ovalid_q;
    obyte_d     = obyte_q;
    olast_d     = olast_q;
    if (emit_i.start) begin
      active_d   = 1'b1;
      rd_idx_d   = '0;
      last_idx_d = emit_i.drop_last ? AW'(FRAME_BYTES - 2) : AW'(FRAME_BYTES - 1);
    end
    if (consume) begin
      ovalid_d = 1'b1;
      obyte_d  = rd_data_i;
      olast_d  = pend_last_q;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
    if (issue) begin
      pend_d      = 1'b1;
      pend_last_d = (rd_idx_q == last_idx_q);
      rd_idx_d    = rd_idx_q + 1'b1;
      if (rd_idx_q == last_idx_q) begin
        active_d = 1'b0;
      end
    end else if (consume) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    last_idx_q  <= last_idx_d;
    pend_last_q <= pend_last_d;
    obyte_q     <= obyte_d;
    olast_q     <= olast_d;
  end

endmodule
`default_nettype wire

@@ hw/rtl/ir_pulse_distance_frame_decoder.sv @@
// Top level of the pulse-distance IR frame decoder.
//
//   Channel  Dir  Handshake       Payload
//   req_i    in   valid/ready     req_type, mark_us, space_us
//   res_o    out  valid/ready     payload_byte, last_byte
//   cfg      in   APB write/read  8 timing registers at 4*index
//
// Each request is decoded in the cycle it is accepted; ready stays high while idle.
// A valid final stop starts a readout of the frame store via its read register,
// one byte per cycle paced by res_o.ready; req_i.ready is low until the
// last byte sits in the output register (FRAME_BYTES or FRAME_BYTES-1 bytes).
// Reset restores register defaults and the leader wait; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module ir_pulse_distance_frame_decoder #(
  parameter int unsigned FRAME_BYTES       = 16,
  parameter int unsigned FIRST_BLOCK_BYTES = 6,
  parameter int unsigned CUSTOMER_BYTES    = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  ipd_in_if.sink                             req_i,
  ipd_out_if.source                          res_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ipd_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [ipd_pkg::ApbDataW-1:0]  pwdata,
  output      logic [ipd_pkg::ApbDataW-1:0]  prdata,
  output      logic                          pready
);
  import ipd_pkg::*;

  localparam int unsigned AW   = $clog2(FRAME_BYTES);
  localparam int unsigned MAX1 = (FRAME_BYTES + 1 > FIRST_BLOCK_BYTES) ?
                                 FRAME_BYTES + 1 : FIRST_BLOCK_BYTES;
  localparam int unsigned MAX2 = (MAX1 > CUSTOMER_BYTES) ? MAX1 : CUSTOMER_BYTES;
  localparam int unsigned CW   = $clog2(MAX2 + 1);

  ipd_cfg_t      cfg;
  ipd_emit_req_t emit_req;
  logic          busy, accept;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  // Input is held off while the store is being read out
  assign req_i.ready = ~busy;
  assign accept      = req_i.valid & ~busy;

  ipd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ipd_decoder #(
    .FRAME_BYTES       (FRAME_BYTES),
    .FIRST_BLOCK_BYTES (FIRST_BLOCK_BYTES),
    .CUSTOMER_BYTES    (CUSTOMER_BYTES),
    .AW                (AW),
    .CW                (CW)
  ) u_dec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .accept_i   (accept),
    .req_type_i (req_i.req_type),
    .mark_us_i  (req_i.mark_us),
    .space_us_i (req_i.space_us),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .emit_o     (emit_req)
  );

  // Writes happen only on accepted requests, reads only while busy: never both
  ipd_frame_store #(
    .DEPTH (FRAME_BYTES),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ipd_emitter #(
    .FRAME_BYTES (FRAME_BYTES),
    .AW          (AW)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit_req),
    .busy_o      (busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_byte_o  (res_o.payload_byte),
    .out_last_o  (res_o.last_byte)
  );

endmodule
`default_nettype wire

@@ test/ir_pulse_distance_frame_decoder_tb.sv @@
// Self-checking bench for the IR frame decoder: directed symbols, then random whole frames.
`timescale 1ns / 1ps
module ir_pulse_distance_frame_decoder_tb;
  import ipd_pkg::*;

  localparam int unsigned FRAME_BYTES       = 16;
  localparam int unsigned FIRST_BLOCK_BYTES = 6;
  localparam int unsigned CUSTOMER_BYTES    = 2;

  // settle time after a drain, before touching registers
  localparam int SETTLE_CYCLES = 8;
  localparam int END_WAIT      = 20;

  // symbol positions inside a built frame: start, leader, bits, gap stop, bits, end stop
  localparam int LEADER_IDX   = 1;
  localparam int FIRST_BIT    = 2;
  localparam int GAP_STOP_IDX = FIRST_BIT + 8 * FIRST_BLOCK_BYTES;
  localparam int END_STOP_IDX = GAP_STOP_IDX + 1 + 8 * (FRAME_BYTES - FIRST_BLOCK_BYTES);

  localparam logic SYM_PAIR  = 1'b0;
  localparam logic SYM_START = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] mark;
    logic [15:0] space;
  } ir_sym_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } ir_byte_t;

  // ways a random frame gets broken, taken in turn
  typedef enum int {
    FAULT_NOISE,
    FAULT_DROP,
    FAULT_RESTART,
    FAULT_EARLY_END,
    FAULT_LATE_GAP,
    FAULT_SHORT_STOP,
    FAULT_BAD_SUM,
    FAULT_TAIL
  } frame_fault_e;
  localparam int FAULT_KINDS = 8;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  ipd_in_if  req_if ();
  ipd_out_if res_if ();

  ir_pulse_distance_frame_decoder #(
    .FRAME_BYTES      (FRAME_BYTES),
    .FIRST_BLOCK_BYTES(FIRST_BLOCK_BYTES),
    .CUSTOMER_BYTES   (CUSTOMER_BYTES)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // decoder mirror: timing registers and frame state
  ipd_cfg_t   timing;
  ipd_phase_e dec_phase;
  logic [2:0] bit_slot;
  logic [7:0] shift_byte;
  int         byte_total;
  logic [7:0] xor_acc;
  logic [7:0] rx_bytes [FRAME_BYTES];

  ir_byte_t expected_bytes_q [$];
  ir_sym_t  frame_q [$];

  int error_count   = 0;
  int good_frames   = 0;
  int live_items    = 0;
  int fault_seq     = 0;
  int src_idle_pct  = 0;
  int rcv_stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("FAIL ir_pulse_distance_frame_decoder");
    $finish;
  end

  // result side backpressure
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // compare each delivered byte with the oldest predicted one
  always @(posedge clk_i) begin : byte_check
    ir_byte_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_bytes_q.size() == 0) begin
        report_mismatch("unexpected payload byte", res_if.payload_byte, 0);
      end else begin
        want = expected_bytes_q.pop_front();
        if (res_if.payload_byte !== want.data)
          report_mismatch("payload_byte", res_if.payload_byte, want.data);
        if (res_if.last_byte !== want.last)
          report_mismatch("last_byte", res_if.last_byte, want.last);
      end
    end
  end

  // ---------------- decoder mirror ----------------

  function automatic logic [16:0] win_lo(input logic [15:0] nom);
    return (nom > timing.tolerance_us) ? {1'b0, nom - timing.tolerance_us} : 17'd0;
  endfunction

  function automatic logic [16:0] win_hi(input logic [15:0] nom);
    return {1'b0, nom} + {1'b0, timing.tolerance_us};
  endfunction

  function automatic logic in_window(input logic [15:0] nom, input logic [15:0] d);
    return ({1'b0, d} >= win_lo(nom)) && ({1'b0, d} <= win_hi(nom));
  endfunction

  task automatic clear_decoder();
    dec_phase  = PH_WAIT_LEADER;
    bit_slot   = 3'd0;
    shift_byte = 8'h00;
    byte_total = 0;
    xor_acc    = 8'h00;
  endtask

  task automatic decode_sym(input ir_sym_t s);
    ir_byte_t want;
    int       n;
    if (s.kind == SYM_START) begin
      clear_decoder();
    end else begin
      case (dec_phase)
        PH_WAIT_LEADER: begin
          if (in_window(timing.leader_mark_us, s.mark) &&
              in_window(timing.leader_space_us, s.space))
            dec_phase = PH_DATA;
          else
            dec_phase = PH_FAIL;
        end
        PH_DATA: begin
          if (!in_window(timing.bit_mark_us, s.mark)) begin
            dec_phase = PH_FAIL;
          end else if (!in_window(timing.zero_space_us, s.space) &&
                       !in_window(timing.one_space_us, s.space)) begin
            dec_phase = PH_FAIL;
          end else begin
            // zero window wins where the two overlap; LSB first
            shift_byte[bit_slot] = !in_window(timing.zero_space_us, s.space);
            bit_slot = bit_slot + 3'd1;
            if (bit_slot == 3'd0) begin
              if (byte_total >= CUSTOMER_BYTES && byte_total < FRAME_BYTES - 1)
                xor_acc = xor_acc ^ shift_byte;
              rx_bytes[byte_total] = shift_byte;
              byte_total++;
              shift_byte = 8'h00;
              if (byte_total == FIRST_BLOCK_BYTES || byte_total >= FRAME_BYTES)
                dec_phase = PH_STOP;
            end
          end
        end
        PH_STOP: begin
          dec_phase = PH_FAIL;
          if (in_window(timing.bit_mark_us, s.mark) &&
              {1'b0, s.space} >= win_lo(timing.gap_space_us)) begin
            if ({1'b0, s.space} <= win_hi(timing.gap_space_us)) begin
              // inter-block gap only allowed after the first block
              if (byte_total == FIRST_BLOCK_BYTES)
                dec_phase = PH_DATA;
            end else if (byte_total == FRAME_BYTES &&
                         (!timing.checksum_enable || xor_acc == rx_bytes[FRAME_BYTES-1])) begin
              n = timing.checksum_enable ? FRAME_BYTES - 1 : FRAME_BYTES;
              for (int k = 0; k < n; k++) begin
                want.data = rx_bytes[k];
                want.last = (k == n - 1);
                expected_bytes_q.push_back(want);
              end
              good_frames++;
              dec_phase = PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  // ---------------- stimulus helpers ----------------

  function automatic ir_sym_t mk_sym(input logic kind, input logic [15:0] m,
                                     input logic [15:0] s);
    ir_sym_t r;
    r.kind  = kind;
    r.mark  = m;
    r.space = s;
    return r;
  endfunction

  // duration inside the window, edges favored
  function automatic logic [15:0] pick_in(input logic [15:0] nom);
    logic [16:0] lo;
    logic [16:0] hi;
    logic [31:0] r;
    lo = win_lo(nom);
    hi = win_hi(nom);
    if (hi > 17'd65535) hi = 17'd65535;
    case ($urandom_range(3))
      0: r = {15'd0, lo};
      1: r = {15'd0, hi};
      default: r = $urandom_range(hi, lo);
    endcase
    return r[15:0];
  endfunction

  function automatic logic [15:0] pick_above(input logic [15:0] nom);
    logic [31:0] r;
    r = $urandom_range(65535, win_hi(nom) + 1);
    return r[15:0];
  endfunction

  function automatic logic [15:0] pick_below(input logic [15:0] nom);
    logic [31:0] r;
    r = $urandom_range(win_lo(nom) - 1, 0);
    return r[15:0];
  endfunction

  // one request; valid stays up after acceptance until the next call or a drain
  task automatic send_sym(input ir_sym_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= s.kind;
    req_if.mark_us  <= s.mark;
    req_if.space_us <= s.space;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (s.kind == SYM_START || (dec_phase != PH_FAIL && dec_phase != PH_DONE))
      live_items++;
    decode_sym(s);
  endtask

  // hold requests until every predicted byte is out and the block is quiet
  task automatic wait_drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input ipd_reg_e idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LEADER_MARK:  timing.leader_mark_us  = val;
      REG_LEADER_SPACE: timing.leader_space_us = val;
      REG_BIT_MARK:     timing.bit_mark_us     = val;
      REG_ZERO_SPACE:   timing.zero_space_us   = val;
      REG_ONE_SPACE:    timing.one_space_us    = val;
      REG_GAP_SPACE:    timing.gap_space_us    = val;
      REG_TOLERANCE:    timing.tolerance_us    = val;
      REG_CHECKSUM_EN:  timing.checksum_enable = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_timing(input logic [15:0] lm, input logic [15:0] ls,
                              input logic [15:0] bm, input logic [15:0] zs,
                              input logic [15:0] os, input logic [15:0] gs,
                              input logic [15:0] tol, input logic ck);
    wait_drain();
    cfg_write(REG_LEADER_MARK, lm);
    cfg_write(REG_LEADER_SPACE, ls);
    cfg_write(REG_BIT_MARK, bm);
    cfg_write(REG_ZERO_SPACE, zs);
    cfg_write(REG_ONE_SPACE, os);
    cfg_write(REG_GAP_SPACE, gs);
    cfg_write(REG_TOLERANCE, tol);
    cfg_write(REG_CHECKSUM_EN, {15'd0, ck});
  endtask

  // well-formed frame with random bytes under the current timing
  task automatic build_frame(input logic bad_sum);
    logic [7:0] bytes [FRAME_BYTES];
    logic [7:0] sum;
    logic [7:0] flip;
    frame_q.delete();
    frame_q.push_back(mk_sym(SYM_START, $urandom, $urandom));
    frame_q.push_back(mk_sym(SYM_PAIR, pick_in(timing.leader_mark_us),
                             pick_in(timing.leader_space_us)));
    sum = 8'h00;
    for (int b = 0; b < FRAME_BYTES; b++) begin
      bytes[b] = $urandom;
      if (b >= CUSTOMER_BYTES && b < FRAME_BYTES - 1) sum = sum ^ bytes[b];
    end
    flip = bad_sum ? (8'h01 << $urandom_range(7)) : 8'h00;
    if (timing.checksum_enable) bytes[FRAME_BYTES-1] = sum ^ flip;
    for (int b = 0; b < FRAME_BYTES; b++) begin
      for (int i = 0; i < 8; i++)
        frame_q.push_back(mk_sym(SYM_PAIR, pick_in(timing.bit_mark_us),
                                 pick_in(bytes[b][i] ? timing.one_space_us
                                                     : timing.zero_space_us)));
      if (b == FIRST_BLOCK_BYTES - 1)
        frame_q.push_back(mk_sym(SYM_PAIR, pick_in(timing.bit_mark_us),
                                 pick_in(timing.gap_space_us)));
    end
    frame_q.push_back(mk_sym(SYM_PAIR, pick_in(timing.bit_mark_us),
                             pick_above(timing.gap_space_us)));
  endtask

  task automatic trim_frame(input int n);
    while (frame_q.size() > n) void'(frame_q.pop_back());
  endtask

  task automatic break_frame(input frame_fault_e fault);
    int idx;
    case (fault)
      FAULT_NOISE: begin
        idx = $urandom_range(END_STOP_IDX, LEADER_IDX);
        frame_q[idx] = mk_sym(SYM_PAIR, $urandom, $urandom);
        trim_frame(idx + 3);
      end
      FAULT_DROP: frame_q.delete($urandom_range(GAP_STOP_IDX - 1, FIRST_BIT));
      // cut short; the next frame start must clear what is left
      FAULT_RESTART: trim_frame($urandom_range(END_STOP_IDX, FIRST_BIT));
      FAULT_EARLY_END: begin
        frame_q[GAP_STOP_IDX].space = pick_above(timing.gap_space_us);
        trim_frame(GAP_STOP_IDX + 2);
      end
      FAULT_LATE_GAP: frame_q[END_STOP_IDX].space = pick_in(timing.gap_space_us);
      FAULT_SHORT_STOP: begin
        if ($urandom_range(1))
          frame_q[END_STOP_IDX].space = pick_below(timing.gap_space_us);
        else
          frame_q[END_STOP_IDX].mark = pick_below(timing.bit_mark_us);
      end
      // pairs after a good end are ignored
      FAULT_TAIL: begin
        repeat ($urandom_range(3, 1))
          frame_q.push_back(mk_sym(SYM_PAIR, pick_in(timing.bit_mark_us), $urandom));
      end
      default: ;
    endcase
  endtask

  // random frames until the item floor is met and at least one frame came out
  task automatic run_frames(input int src_pct, input int rcv_pct, input int min_items);
    int           first_items;
    int           first_frames;
    frame_fault_e fault;
    src_idle_pct  = src_pct;
    rcv_stall_pct = rcv_pct;
    first_items   = live_items;
    first_frames  = good_frames;
    while (live_items - first_items < min_items || good_frames == first_frames) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(3, 1))
          send_sym(mk_sym($urandom_range(1), $urandom, $urandom));
      end
      if ($urandom_range(9) < 4) begin
        fault = frame_fault_e'(fault_seq % FAULT_KINDS);
        fault_seq++;
        build_frame(fault == FAULT_BAD_SUM);
        break_frame(fault);
      end else begin
        build_frame(1'b0);
      end
      foreach (frame_q[i]) send_sym(frame_q[i]);
      if ($urandom_range(5) == 0) wait_drain();
    end
    wait_drain();
  endtask

  // ---------------- tests ----------------

  // window edges, bad leaders and bits, ignored pairs, tolerance extremes
  task automatic test_symbol_checks();
    send_sym(mk_sym(SYM_START, 16'hFFFF, 16'hFFFF));
    send_sym(mk_sym(SYM_PAIR, 16'd8800, 16'd4700));
    send_sym(mk_sym(SYM_PAIR, 16'd360, 16'd1890));
    send_sym(mk_sym(SYM_PAIR, 16'd760, 16'd360));
    send_sym(mk_sym(SYM_PAIR, 16'd761, 16'd560));
    send_sym(mk_sym(SYM_PAIR, 16'hFFFF, 16'hFFFF));
    send_sym(mk_sym(SYM_START, 16'h0000, 16'h0000));
    send_sym(mk_sym(SYM_PAIR, 16'd8799, 16'd4500));
    send_sym(mk_sym(SYM_START, 16'hAAAA, 16'h5555));
    send_sym(mk_sym(SYM_PAIR, 16'd9200, 16'd4300));
    send_sym(mk_sym(SYM_PAIR, 16'd560, 16'd1489));
    send_sym(mk_sym(SYM_PAIR, 16'h0000, 16'h0000));
    send_sym(mk_sym(SYM_START, 16'h5555, 16'hAAAA));
    send_sym(mk_sym(SYM_PAIR, 16'd9000, 16'd4701));
    send_sym(mk_sym(SYM_START, 16'h0000, 16'h0000));
    // widest tolerance: lower edge clamps, upper edge must not wrap
    wait_drain();
    cfg_write(REG_TOLERANCE, 16'hFFFF);
    send_sym(mk_sym(SYM_PAIR, 16'h0000, 16'h0000));
    send_sym(mk_sym(SYM_PAIR, 16'hFFFF, 16'hFFFF));
    send_sym(mk_sym(SYM_START, 16'h1234, 16'h4321));
    // exact match only, leader at the top and bottom of the range
    wait_drain();
    cfg_write(REG_TOLERANCE, 16'h0000);
    cfg_write(REG_LEADER_MARK, 16'hFFFF);
    cfg_write(REG_LEADER_SPACE, 16'h0000);
    send_sym(mk_sym(SYM_PAIR, 16'hFFFF, 16'h0000));
    send_sym(mk_sym(SYM_PAIR, 16'd560, 16'd560));
    send_sym(mk_sym(SYM_PAIR, 16'd560, 16'd561));
    send_sym(mk_sym(SYM_START, 16'h0000, 16'hFFFF));
    send_sym(mk_sym(SYM_PAIR, 16'hFFFE, 16'h0000));
    send_sym(mk_sym(SYM_START, 16'hFFFF, 16'h0000));
    wait_drain();
  endtask

  task automatic test_default_timing();
    apply_timing(RstLeaderMark, RstLeaderSpace, RstBitMark, RstZeroSpace,
                 RstOneSpace, RstGapSpace, RstTolerance, RstChecksumEn);
    run_frames(0, 0, 82);
  endtask

  task automatic test_exact_timing_no_checksum();
    apply_timing(16'hFFFF, 16'h0000, 16'd100, 16'd300, 16'd600, 16'd2000, 16'd0, 1'b0);
    run_frames(88, 0, 82);
  endtask

  task automatic test_wide_nominals();
    apply_timing(16'h0000, 16'hFFFF, 16'd560, 16'd560, 16'd1690, 16'd30000, 16'd150, 1'b1);
    run_frames(0, 88, 82);
  endtask

  task automatic test_mixed_stalls();
    apply_timing(16'd4000, 16'd2000, 16'd300, 16'd300, 16'd900, 16'd5000, 16'd120, 1'b1);
    run_frames(24, 24, 82);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= SYM_PAIR;
    req_if.mark_us  <= 16'h0000;
    req_if.space_us <= 16'h0000;
    timing.leader_mark_us  = RstLeaderMark;
    timing.leader_space_us = RstLeaderSpace;
    timing.bit_mark_us     = RstBitMark;
    timing.zero_space_us   = RstZeroSpace;
    timing.one_space_us    = RstOneSpace;
    timing.gap_space_us    = RstGapSpace;
    timing.tolerance_us    = RstTolerance;
    timing.checksum_enable = RstChecksumEn;
    clear_decoder();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_symbol_checks();
    test_default_timing();
    test_exact_timing_no_checksum();
    test_wide_nominals();
    test_mixed_stalls();

    repeat (END_WAIT) @(posedge clk_i);
    if (error_count == 0)
      $display("PASS ir_pulse_distance_frame_decoder");
    else
      $display("FAIL ir_pulse_distance_frame_decoder");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ipd_pkg.sv
hw/rtl/ipd_in_if.sv
hw/rtl/ipd_out_if.sv
hw/rtl/ipd_cfg_regs.sv
hw/rtl/ipd_frame_store.sv
hw/rtl/ipd_decoder.sv
hw/rtl/ipd_emitter.sv
hw/rtl/ir_pulse_distance_frame_decoder.sv
test/ir_pulse_distance_frame_decoder_tb.sv
